>>> hdl/fbc_pkg.sv
// Shared types and constants for the frustum box cull unit.
`default_nettype none
package fbc_pkg;

   localparam int NUM_PLANES_DEF  = 6;
   localparam int COORD_WIDTH_DEF = 24;
   localparam int NORMAL_W        = 16;
   localparam int OFFSET_W        = 41;
   localparam int SLOT_W          = 3;
   localparam int NORMALS_W       = 3 * NORMAL_W;
   localparam int ENTRY_W         = NORMALS_W + OFFSET_W;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TEST = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic valid;
      logic last;
   } eval_ctl_type;

   typedef struct packed {
      logic valid;
      logic last;
      logic reject;
   } eval_res_type;

endpackage
`default_nettype wire

>>> hdl/fbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fbc_ram #(
   parameter int WIDTH = fbc_pkg::ENTRY_W,
   parameter int DEPTH = fbc_pkg::NUM_PLANES_DEF,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> hdl/fbc_plane_eval.sv
// Plane test pipeline: nearest-corner distance and its sign, one plane per cycle.
`default_nettype none
module fbc_plane_eval #(
   parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire fbc_pkg::eval_ctl_type                ctl_in,
   input  wire logic                                 entry_hit,
   input  wire logic [fbc_pkg::ENTRY_W-1:0]          entry,
   input  wire logic [2:0][COORD_WIDTH-1:0]          near_pt,
   input  wire logic [2:0][COORD_WIDTH-1:0]          far_pt,
   output fbc_pkg::eval_res_type                     res
);

   localparam int PROD_W = fbc_pkg::NORMAL_W + COORD_WIDTH;
   localparam int BASE_W = (PROD_W > fbc_pkg::OFFSET_W) ? PROD_W : fbc_pkg::OFFSET_W;
   localparam int SUM_W  = BASE_W + 2;

   logic [fbc_pkg::ENTRY_W-1:0]          plane;
   logic signed [fbc_pkg::NORMAL_W-1:0]  nrm [3];
   logic signed [COORD_WIDTH-1:0]        pnt [3];
   logic signed [PROD_W-1:0]             prod_in [3];
   logic signed [PROD_W-1:0]             prod_ff [3];
   logic signed [fbc_pkg::OFFSET_W-1:0]  ofs_in;
   logic signed [fbc_pkg::OFFSET_W-1:0]  ofs_ff;
   logic signed [SUM_W-1:0]              sum0_in;
   logic signed [SUM_W-1:0]              sum1_in;
   logic signed [SUM_W-1:0]              sum0_ff;
   logic signed [SUM_W-1:0]              sum1_ff;
   logic signed [SUM_W-1:0]              total;
   fbc_pkg::eval_ctl_type                ctl1_ff;
   fbc_pkg::eval_ctl_type                ctl2_ff;
   fbc_pkg::eval_res_type                res_in;
   fbc_pkg::eval_res_type                res_ff;

   // never-loaded planes read as zero
   always_comb begin
      plane  = entry_hit ? entry : '0;
      ofs_in = $signed(plane[fbc_pkg::ENTRY_W-1:fbc_pkg::NORMALS_W]);
      for (int a = 0; a < 3; a++) begin
         nrm[a]     = $signed(plane[a*fbc_pkg::NORMAL_W +: fbc_pkg::NORMAL_W]);
         pnt[a]     = nrm[a][fbc_pkg::NORMAL_W-1] ? $signed(far_pt[a]) : $signed(near_pt[a]);
         prod_in[a] = nrm[a] * pnt[a];
      end
   end

   always_comb begin
      sum0_in = SUM_W'(ofs_ff) + SUM_W'(prod_ff[0]);
      sum1_in = SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2]);
      total   = sum0_ff + sum1_ff;
      res_in.valid  = ctl2_ff.valid;
      res_in.last   = ctl2_ff.last;
      res_in.reject = ~total[SUM_W-1];
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         prod_ff[a] <= prod_in[a];
      end
      ofs_ff  <= ofs_in;
      sum0_ff <= sum0_in;
      sum1_ff <= sum1_in;
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         res_ff  <= '0;
      end else begin
         ctl1_ff <= ctl_in;
         ctl2_ff <= ctl1_ff;
         res_ff  <= res_in;
      end
   end

   assign res = res_ff;

endmodule
`default_nettype wire

>>> hdl/frustum_box_cull_unit.sv
// Top level of the frustum box cull unit: plane store, scan sequencer and result register.
// A load transfer (kind 0) writes one plane into the plane memory; a slot at or beyond
// NUM_PLANES is ignored, and planes never loaded read as zero, so every box is culled
// until all planes are written. A test transfer (kind 1) holds req_stall high while
// the scan reads each plane in turn from the single-read-port plane memory, the drain
// carries the last plane through read data, multiply, add and sign, and the done state
// posts the result (held there while an earlier result waits on rsp_stall). No new
// transfer is taken until the test has posted its result.
// Each plane is checked only at the box corner nearest its inside half-space; the box is
// culled (rsp_visible = 0) when that distance is zero or positive for some plane. A new
// transfer is taken while a finished result still waits on rsp_stall.
`default_nettype none
module frustum_box_cull_unit #(
   parameter int NUM_PLANES  = fbc_pkg::NUM_PLANES_DEF,
   parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_kind,
   input  wire logic [fbc_pkg::SLOT_W-1:0]          req_plane_slot,
   input  wire logic signed [fbc_pkg::NORMAL_W-1:0] req_normal_x,
   input  wire logic signed [fbc_pkg::NORMAL_W-1:0] req_normal_y,
   input  wire logic signed [fbc_pkg::NORMAL_W-1:0] req_normal_z,
   input  wire logic signed [fbc_pkg::OFFSET_W-1:0] req_plane_offset,
   input  wire logic signed [COORD_WIDTH-1:0]       req_box_min_x,
   input  wire logic signed [COORD_WIDTH-1:0]       req_box_min_y,
   input  wire logic signed [COORD_WIDTH-1:0]       req_box_min_z,
   input  wire logic signed [COORD_WIDTH-1:0]       req_box_max_x,
   input  wire logic signed [COORD_WIDTH-1:0]       req_box_max_y,
   input  wire logic signed [COORD_WIDTH-1:0]       req_box_max_z,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_visible
);

   localparam int IDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

   fbc_pkg::state_type                 state_ff;
   fbc_pkg::state_type                 state_in;
   logic [IDX_W-1:0]                   scan_idx_ff;
   logic [IDX_W-1:0]                   scan_idx_in;
   logic [NUM_PLANES-1:0]              plane_vld_ff;
   logic [NUM_PLANES-1:0]              plane_vld_in;
   fbc_pkg::eval_ctl_type              rd_ctl_ff;
   fbc_pkg::eval_ctl_type              rd_ctl_in;
   logic                               rd_hit_ff;
   logic [2:0][COORD_WIDTH-1:0]        near_ff;
   logic [2:0][COORD_WIDTH-1:0]        far_ff;
   logic [2:0][COORD_WIDTH-1:0]        near_in;
   logic [2:0][COORD_WIDTH-1:0]        far_in;
   logic                               culled_ff;
   logic                               culled_in;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic                               rsp_visible_ff;
   logic                               rsp_visible_in;

   logic                               busy;
   logic                               rd_en;
   logic                               scan_last;
   logic                               post_ok;
   logic                               req_xfer;
   logic                               load_xfer;
   logic                               test_xfer;
   logic                               slot_ok;
   logic [IDX_W-1:0]                   wr_addr;
   logic [fbc_pkg::ENTRY_W-1:0]        wr_data;
   logic [fbc_pkg::ENTRY_W-1:0]        rd_data;
   logic signed [COORD_WIDTH-1:0]      box_lo [3];
   logic signed [COORD_WIDTH-1:0]      box_hi [3];
   fbc_pkg::eval_res_type              eval_res;

   assign req_xfer  = req_valid && !req_stall;
   assign load_xfer = req_xfer && (req_kind == fbc_pkg::KIND_LOAD);
   assign test_xfer = req_xfer && (req_kind == fbc_pkg::KIND_TEST);
   assign slot_ok   = int'(req_plane_slot) < NUM_PLANES;
   assign wr_addr   = IDX_W'(req_plane_slot);
   assign wr_data   = {req_plane_offset, req_normal_z, req_normal_y, req_normal_x};
   assign scan_last = (scan_idx_ff == IDX_W'(NUM_PLANES - 1));
   assign post_ok   = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fbc_pkg::ST_IDLE: begin
            if (test_xfer) begin
               state_in = fbc_pkg::ST_SCAN;
            end
         end
         fbc_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = fbc_pkg::ST_DRAIN;
            end
         end
         fbc_pkg::ST_DRAIN: begin
            if (eval_res.valid && eval_res.last) begin
               state_in = fbc_pkg::ST_DONE;
            end
         end
         fbc_pkg::ST_DONE: begin
            if (post_ok) begin
               state_in = fbc_pkg::ST_IDLE;
            end
         end
         default: state_in = fbc_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      busy  = 1'b1;
      rd_en = 1'b0;
      case (state_ff)
         fbc_pkg::ST_IDLE:  busy = 1'b0;
         fbc_pkg::ST_SCAN:  rd_en = 1'b1;
         fbc_pkg::ST_DRAIN: busy = 1'b1;
         fbc_pkg::ST_DONE:  busy = 1'b1;
         default:           busy = 1'b1;
      endcase
   end

   assign req_stall = busy;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         box_lo[a] = '0;
         box_hi[a] = '0;
      end
      box_lo[0] = req_box_min_x;
      box_lo[1] = req_box_min_y;
      box_lo[2] = req_box_min_z;
      box_hi[0] = req_box_max_x;
      box_hi[1] = req_box_max_y;
      box_hi[2] = req_box_max_z;
      for (int a = 0; a < 3; a++) begin
         if (box_lo[a] > box_hi[a]) begin
            near_in[a] = box_hi[a];
            far_in[a]  = box_lo[a];
         end else begin
            near_in[a] = box_lo[a];
            far_in[a]  = box_hi[a];
         end
      end
   end

   always_comb begin
      scan_idx_in = scan_idx_ff;
      if (test_xfer) begin
         scan_idx_in = '0;
      end else if (rd_en && !scan_last) begin
         scan_idx_in = scan_idx_ff + 1'b1;
      end

      plane_vld_in = plane_vld_ff;
      if (load_xfer && slot_ok) begin
         plane_vld_in[wr_addr] = 1'b1;
      end

      rd_ctl_in.valid = rd_en;
      rd_ctl_in.last  = rd_en && scan_last;

      culled_in = culled_ff;
      if (test_xfer) begin
         culled_in = 1'b0;
      end else if (eval_res.valid) begin
         culled_in = culled_ff | eval_res.reject;
      end

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_visible_in = rsp_visible_ff;
      if ((state_ff == fbc_pkg::ST_DONE) && post_ok) begin
         rsp_valid_in   = 1'b1;
         rsp_visible_in = !culled_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_hit_ff      <= plane_vld_ff[scan_idx_ff];
      rsp_visible_ff <= rsp_visible_in;
      culled_ff      <= culled_in;
      if (test_xfer) begin
         near_ff <= near_in;
         far_ff  <= far_in;
      end
      if (reset) begin
         state_ff     <= fbc_pkg::ST_IDLE;
         scan_idx_ff  <= '0;
         plane_vld_ff <= '0;
         rd_ctl_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_idx_ff  <= scan_idx_in;
         plane_vld_ff <= plane_vld_in;
         rd_ctl_ff    <= rd_ctl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   fbc_ram #(
      .WIDTH (fbc_pkg::ENTRY_W),
      .DEPTH (NUM_PLANES)
   ) u_plane_ram (
      .clock   (clock),
      .wr_en   (load_xfer && slot_ok),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_data)
   );

   fbc_plane_eval #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_plane_eval (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (rd_ctl_ff),
      .entry_hit (rd_hit_ff),
      .entry     (rd_data),
      .near_pt   (near_ff),
      .far_pt    (far_ff),
      .res       (eval_res)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_visible = rsp_visible_ff;

   a_res_in_scan: assert property (@(posedge clock) disable iff (reset)
      eval_res.valid |-> (state_ff == fbc_pkg::ST_SCAN || state_ff == fbc_pkg::ST_DRAIN))
      else $error("plane result outside a box test");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == fbc_pkg::ST_DONE))
      else $error("result posted outside done state");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fbc_pkg::ST_SCAN) |-> (int'(scan_idx_ff) < NUM_PLANES))
      else $error("scan index out of range");

   a_last_read_ends_scan: assert property (@(posedge clock) disable iff (reset)
      rd_ctl_in.last |=> (state_ff == fbc_pkg::ST_DRAIN))
      else $error("last plane read did not end the scan");

endmodule
`default_nettype wire

>>> dv/frustum_box_cull_unit_test.sv
// Self-checking testbench for frustum_box_cull_unit: plane loads and box visibility tests.
`timescale 1ns / 100ps
module frustum_box_cull_unit_test;

   localparam int NUM_PLANES = fbc_pkg::NUM_PLANES_DEF;
   localparam int CW         = fbc_pkg::COORD_WIDTH_DEF;
   localparam int NORMAL_W   = fbc_pkg::NORMAL_W;
   localparam int OFFSET_W   = fbc_pkg::OFFSET_W;
   localparam int SLOT_W     = fbc_pkg::SLOT_W;
   localparam logic KIND_LOAD = fbc_pkg::KIND_LOAD;
   localparam logic KIND_TEST = fbc_pkg::KIND_TEST;
   localparam int DUE_DEPTH  = 4096;

   localparam logic CHK_MODEL = 1'b0;
   localparam logic CHK_TYPED = 1'b1;

   localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic [OFFSET_W-1:0] DMIN = {1'b1, {(OFFSET_W-1){1'b0}}};
   localparam logic [OFFSET_W-1:0] DMAX = {1'b0, {(OFFSET_W-1){1'b1}}};

   typedef struct packed {
      logic                       kind;
      logic [SLOT_W-1:0]          slot;
      logic signed [NORMAL_W-1:0] nx;
      logic signed [NORMAL_W-1:0] ny;
      logic signed [NORMAL_W-1:0] nz;
      logic signed [OFFSET_W-1:0] off;
      logic signed [CW-1:0]       lo_x;
      logic signed [CW-1:0]       lo_y;
      logic signed [CW-1:0]       lo_z;
      logic signed [CW-1:0]       hi_x;
      logic signed [CW-1:0]       hi_y;
      logic signed [CW-1:0]       hi_z;
   } cull_item_type;

   typedef struct packed {
      cull_item_type item;
      logic          chk;
      logic          vis;
   } cull_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_kind = 1'b0;
   logic [SLOT_W-1:0]          req_plane_slot = '0;
   logic signed [NORMAL_W-1:0] req_normal_x = '0;
   logic signed [NORMAL_W-1:0] req_normal_y = '0;
   logic signed [NORMAL_W-1:0] req_normal_z = '0;
   logic signed [OFFSET_W-1:0] req_plane_offset = '0;
   logic signed [CW-1:0]       req_box_min_x = '0;
   logic signed [CW-1:0]       req_box_min_y = '0;
   logic signed [CW-1:0]       req_box_min_z = '0;
   logic signed [CW-1:0]       req_box_max_x = '0;
   logic signed [CW-1:0]       req_box_max_y = '0;
   logic signed [CW-1:0]       req_box_max_z = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_visible;

   logic signed [NORMAL_W-1:0] frustum_nx [NUM_PLANES];
   logic signed [NORMAL_W-1:0] frustum_ny [NUM_PLANES];
   logic signed [NORMAL_W-1:0] frustum_nz [NUM_PLANES];
   logic signed [OFFSET_W-1:0] frustum_d  [NUM_PLANES];

   logic visible_due [DUE_DEPTH];
   int   due_wr = 0;
   int   due_rd = 0;
   logic due_vis;
   int   mismatches = 0;
   int   send_idle_pct = 32;
   int   rsp_stall_pct = 85;

   cull_row_type directed_rows [23] = '{
      '{'{KIND_TEST, 3'd0, 16'sd0, 16'sd0, 16'sd0, 41'sd0,
          CMIN, CMIN, CMIN, CMAX, CMAX, CMAX}, CHK_TYPED, 1'b0},
      '{'{KIND_TEST, 3'd0, 16'sd0, 16'sd0, 16'sd0, 41'sd0,
          24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0}, CHK_TYPED, 1'b0},
      '{'{KIND_LOAD, 3'd6, 16'sd16384, 16'sd0, 16'sd0, -41'sd16384000,
          24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0}, CHK_MODEL, 1'b0},
      '{'{KIND_LOAD, 3'd7, 16'h8000, 16'h7FFF, 16'h8000, DMIN,
          CMAX, CMIN, CMAX, CMIN, CMAX, CMIN}, CHK_MODEL, 1'b0},
      '{'{KIND_TEST, 3'd7, 16'h7FFF, 16'h8000, 16'h7FFF, DMAX,
          CMIN, CMIN, CMIN, CMAX, CMAX, CMAX}, CHK_TYPED, 1'b0},
      '{'{KIND_LOAD, 3'd0, 16'sd16384, 16'sd0, 16'sd0, -41'sd16384000,
          24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0}, CHK_MODEL, 1'b0},
      '{'{KIND_LOAD, 3'd1, -16'sd16384, 16'sd0, 16'sd0, -41'sd16384000,
          24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0}, CHK_MODEL, 1'b0},
      '{'{KIND_LOAD, 3'd2, 16'sd0, 16'sd16384, 16'sd0, -41'sd16384000,
          24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0}, CHK_MODEL, 1'b0},
      '{'{KIND_LOAD, 3'd3, 16'sd0, -16'sd16384, 16'sd0, -41'sd16384000,
          24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0}, CHK_MODEL, 1'b0},
      '{'{KIND_LOAD, 3'd4, 16'sd0, 16'sd0, 16'sd16384, -41'sd16384000,
          24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0}, CHK_MODEL, 1'b0},
      '{'{KIND_LOAD, 3'd5, 16'sd0, 16'sd0, -16'sd16384, -41'sd16384000,
          24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0}, CHK_MODEL, 1'b0},
      '{'{KIND_TEST, 3'd0, 16'sd0, 16'sd0, 16'sd0, 41'sd0,
          24'sd0, 24'sd0, 24'sd0, 24'sd10, 24'sd10, 24'sd10}, CHK_MODEL, 1'b0},
      '{'{KIND_TEST, 3'd0, 16'sd0, 16'sd0, 16'sd0, 41'sd0,
          24'sd5000, 24'sd0, 24'sd0, 24'sd6000, 24'sd10, 24'sd10}, CHK_MODEL, 1'b0},
      '{'{KIND_TEST, 3'd0, 16'sd0, 16'sd0, 16'sd0, 41'sd0,
          -24'sd2000, -24'sd2000, -24'sd2000, 24'sd2000, 24'sd2000, 24'sd2000},
          CHK_MODEL, 1'b0},
      '{'{KIND_TEST, 3'd0, 16'sd0, 16'sd0, 16'sd0, 41'sd0,
          24'sd10, 24'sd10, 24'sd10, -24'sd10, -24'sd10, -24'sd10}, CHK_MODEL, 1'b0},
      '{'{KIND_TEST, 3'd0, 16'sd0, 16'sd0, 16'sd0, 41'sd0,
          24'sd1000, 24'sd0, 24'sd0, 24'sd1200, 24'sd10, 24'sd10}, CHK_MODEL, 1'b0},
      '{'{KIND_LOAD, 3'd0, 16'h8000, 16'h8000, 16'h8000, DMIN,
          CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, CHK_MODEL, 1'b0},
      '{'{KIND_TEST, 3'd0, 16'sd0, 16'sd0, 16'sd0, 41'sd0,
          CMIN, CMIN, CMIN, CMAX, CMAX, CMAX}, CHK_MODEL, 1'b0},
      '{'{KIND_LOAD, 3'd1, 16'h7FFF, 16'h7FFF, 16'h7FFF, DMAX,
          CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}, CHK_MODEL, 1'b0},
      '{'{KIND_TEST, 3'd0, 16'sd0, 16'sd0, 16'sd0, 41'sd0,
          CMIN, CMIN, CMIN, CMAX, CMAX, CMAX}, CHK_MODEL, 1'b0},
      '{'{KIND_TEST, 3'd0, 16'sd0, 16'sd0, 16'sd0, 41'sd0,
          CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, CHK_MODEL, 1'b0},
      '{'{KIND_LOAD, 3'd2, 16'sd0, 16'sd0, 16'sd0, 41'sd0,
          24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0}, CHK_MODEL, 1'b0},
      '{'{KIND_TEST, 3'd0, 16'sd0, 16'sd0, 16'sd0, 41'sd0,
          24'sd0, 24'sd0, 24'sd0, 24'sd10, 24'sd10, 24'sd10}, CHK_TYPED, 1'b0}
   };

   frustum_box_cull_unit u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 100)
         $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   function automatic void store_plane(input cull_item_type it);
      if (it.slot < NUM_PLANES) begin
         frustum_nx[it.slot] = it.nx;
         frustum_ny[it.slot] = it.ny;
         frustum_nz[it.slot] = it.nz;
         frustum_d[it.slot]  = it.off;
      end
   endfunction

   // culled when some plane has no corner at a negative distance
   function automatic logic box_visible(input cull_item_type it);
      longint corner_dist;
      logic   rejects;
      int     p;
      int     c;
      for (p = 0; p < NUM_PLANES; p++) begin
         rejects = 1'b1;
         for (c = 0; c < 8; c++) begin
            corner_dist = longint'(frustum_d[p]);
            corner_dist += longint'(frustum_nx[p]) * longint'(c[0] ? it.hi_x : it.lo_x);
            corner_dist += longint'(frustum_ny[p]) * longint'(c[1] ? it.hi_y : it.lo_y);
            corner_dist += longint'(frustum_nz[p]) * longint'(c[2] ? it.hi_z : it.lo_z);
            if (corner_dist < 0)
               rejects = 1'b0;
         end
         if (rejects)
            return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic longint rand_span(input int bits);
      longint v;
      v = longint'({$urandom, $urandom});
      return v >>> (64 - bits);
   endfunction

   function automatic cull_item_type noise_item();
      cull_item_type it;
      it.kind = 1'($urandom);
      it.slot = SLOT_W'($urandom);
      it.nx   = NORMAL_W'($urandom);
      it.ny   = NORMAL_W'($urandom);
      it.nz   = NORMAL_W'($urandom);
      it.off  = OFFSET_W'({$urandom, $urandom});
      it.lo_x = CW'($urandom);
      it.lo_y = CW'($urandom);
      it.lo_z = CW'($urandom);
      it.hi_x = CW'($urandom);
      it.hi_y = CW'($urandom);
      it.hi_z = CW'($urandom);
      return it;
   endfunction

   task automatic send_item(input cull_item_type it, input logic chk, input logic typed_vis);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= it.kind;
      req_plane_slot   <= it.slot;
      req_normal_x     <= it.nx;
      req_normal_y     <= it.ny;
      req_normal_z     <= it.nz;
      req_plane_offset <= it.off;
      req_box_min_x    <= it.lo_x;
      req_box_min_y    <= it.lo_y;
      req_box_min_z    <= it.lo_z;
      req_box_max_x    <= it.hi_x;
      req_box_max_y    <= it.hi_y;
      req_box_max_z    <= it.hi_z;
      do @(posedge clock); while (req_stall);
      if (it.kind == KIND_LOAD) begin
         store_plane(it);
      end else begin
         visible_due[due_wr % DUE_DEPTH] = (chk == CHK_TYPED) ? typed_vis : box_visible(it);
         due_wr++;
      end
      @(negedge clock);
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (due_wr != due_rd)
         @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_wr == due_rd) begin
            report_mismatch("result transfer with nothing expected");
         end else begin
            due_vis = visible_due[due_rd % DUE_DEPTH];
            due_rd++;
            if (rsp_visible !== due_vis)
               report_mismatch($sformatf("visible %b, expected %b", rsp_visible, due_vis));
         end
      end
   end

   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      cull_item_type it;
      int            phase;
      int            issued;
      int            s;
      int            n;
      longint        cx, cy, cz;
      longint        r, ox, oy, oz, hx, hy, hz;
      int            k;
      for (s = 0; s < NUM_PLANES; s++) begin
         frustum_nx[s] = '0;
         frustum_ny[s] = '0;
         frustum_nz[s] = '0;
         frustum_d[s]  = '0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].chk, directed_rows[i].vis);
      wait_results_drained();

      issued = 0;
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 32; rsp_stall_pct = 85; end
            1: begin send_idle_pct = 85; rsp_stall_pct = 32; end
            default: begin send_idle_pct = 0; rsp_stall_pct = 0; end
         endcase
         while (issued < (phase + 1) * 270) begin
            if ($urandom_range(99) < 70) begin
               // planes placed around a common center, then boxes near it
               cx = rand_span(21);
               cy = rand_span(21);
               cz = rand_span(21);
               for (s = 0; s < NUM_PLANES; s++) begin
                  it = noise_item();
                  it.kind = KIND_LOAD;
                  it.slot = SLOT_W'(s);
                  k = $urandom_range(20, 36);
                  r = rand_span(k) - (longint'(1) <<< (k - 2));
                  it.off = OFFSET_W'(r - longint'(it.nx) * cx - longint'(it.ny) * cy
                                     - longint'(it.nz) * cz);
                  send_item(it, CHK_MODEL, 1'b0);
                  issued++;
               end
               n = $urandom_range(4, 12);
               repeat (n) begin
                  it = noise_item();
                  it.kind = KIND_TEST;
                  ox = rand_span($urandom_range(2, 21));
                  oy = rand_span($urandom_range(2, 21));
                  oz = rand_span($urandom_range(2, 21));
                  hx = rand_span($urandom_range(2, 20));
                  hy = rand_span($urandom_range(2, 20));
                  hz = rand_span($urandom_range(2, 20));
                  if ($urandom_range(9) != 0) begin
                     if (hx < 0) hx = -hx;
                     if (hy < 0) hy = -hy;
                     if (hz < 0) hz = -hz;
                  end
                  it.lo_x = CW'(cx + ox - hx);
                  it.lo_y = CW'(cy + oy - hy);
                  it.lo_z = CW'(cz + oz - hz);
                  it.hi_x = CW'(cx + ox + hx);
                  it.hi_y = CW'(cy + oy + hy);
                  it.hi_z = CW'(cz + oz + hz);
                  send_item(it, CHK_MODEL, 1'b0);
                  issued++;
               end
            end else begin
               n = $urandom_range(1, 8);
               repeat (n) begin
                  send_item(noise_item(), CHK_MODEL, 1'b0);
                  issued++;
               end
            end
         end
         if (phase == 0)
            wait_results_drained();
      end

      wait_results_drained();
      repeat (NUM_PLANES + 20) @(negedge clock);
      if (mismatches == 0 && due_wr == due_rd)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> frustum_box_cull_unit.f
hdl/fbc_pkg.sv
hdl/fbc_ram.sv
hdl/fbc_plane_eval.sv
hdl/frustum_box_cull_unit.sv
dv/frustum_box_cull_unit_test.sv
